@@ hdl/txtc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// txtc_pkg
// Shared constants, types and helpers of the text cursor glyph rasterizer.
// ----------------------------------------------------------------------------
package txtc_pkg;

    localparam int GLYPH_WIDTH     = 8;
    localparam int GLYPH_HEIGHT    = 8;
    localparam int GLYPH_COUNT     = 128;
    localparam int BYTES_PER_LINE  = 1;
    localparam int BYTES_PER_GLYPH = 8;

    localparam int ADDR_W  = 10;
    localparam int CODE_W  = 8;
    localparam int BYTE_W  = 8;
    localparam int COORD_W = 16;
    localparam int MASK_W  = 64;
    localparam int COLOR_W = 32;
    localparam int ZOOM_W  = 4;
    localparam int CFG_IDX_W = 8;
    localparam int ROW_W   = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
    localparam int REP_W   = 3;

    localparam logic [CODE_W-1:0] CODE_CR = 8'd13;
    localparam logic [CODE_W-1:0] CODE_LF = 8'd10;
    localparam logic [ZOOM_W-1:0] ZOOM_MAX = 4'd8;
    localparam logic [COORD_W-1:0] COORD_MAX = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZOOM       = 8'd1;

    localparam logic [COLOR_W-1:0] DRAW_COLOR_RST = 32'hFFFF_FFFF;
    localparam logic [ZOOM_W-1:0]  ZOOM_RST       = 4'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wdata;
    } glyph_req_t;

    // spread each glyph bit over zoom mask bits, lsb first
    function automatic logic [MASK_W-1:0] expand_row(input logic [BYTE_W-1:0] bits,
                                                     input logic [ZOOM_W-1:0] zoom);
        logic [MASK_W-1:0] zm;
        logic [MASK_W-1:0] m;
        zm = (MASK_W'(1) << zoom) - MASK_W'(1);
        m  = '0;
        for (int j = 0; j < GLYPH_WIDTH; j++) begin
            if (bits[j]) begin
                m = m | (zm << (j * int'(zoom)));
            end
        end
        return m;
    endfunction

    function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        logic [COORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COORD_W] ? COORD_MAX : s[COORD_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ hdl/txtc_glyph_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// txtc_glyph_ram
// Single-port glyph store, one byte wide, registered read data.
// ----------------------------------------------------------------------------
module txtc_glyph_ram
    import txtc_pkg::*;
(
    input  wire logic              aclk,
    input  wire glyph_req_t        req,
    output logic [BYTE_W-1:0]      rdata
);

    logic [BYTE_W-1:0] mem [0:(1 << ADDR_W)-1];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.addr] <= req.wdata;
        end
        rdata <= mem[req.addr];
    end

endmodule
`default_nettype wire

@@ hdl/txtc_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// txtc_seq
// Cursor keeper and row sequencer: fetches glyph rows, expands them by zoom
// and presents one row word at a time.
// ----------------------------------------------------------------------------
module txtc_seq
    import txtc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic               action,
    input  wire logic [CODE_W-1:0]  char_code,
    input  wire logic [ADDR_W-1:0]  font_addr,
    input  wire logic [BYTE_W-1:0]  font_data,
    input  wire logic [ZOOM_W-1:0]  zoom_factor,
    output glyph_req_t              ram_req,
    input  wire logic [BYTE_W-1:0]  ram_rdata,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [COORD_W-1:0]      row_x,
    output logic [COORD_W-1:0]      row_y,
    output logic [MASK_W-1:0]       row_mask,
    output logic                    last_row
);

    seq_state_t state_reg, state_next;

    logic [COORD_W-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_W-1:0] cursor_y_reg, cursor_y_next;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [MASK_W-1:0]  mask_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic [ZOOM_W-1:0]  z_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [REP_W-1:0]   rep_reg;

    logic [ZOOM_W-1:0]  z_eff;
    logic               s_fire;
    logic               m_fire;
    logic               is_glyph;
    logic               rep_end;
    logic               row_end;
    logic [ADDR_W-1:0]  glyph_base;
    logic [ADDR_W-1:0]  row_addr;

    assign z_eff    = (zoom_factor > ZOOM_MAX) ? ZOOM_MAX : zoom_factor;
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;
    assign is_glyph = !action && (char_code != CODE_CR) && (char_code != CODE_LF)
                      && (z_eff != '0);
    assign rep_end  = ({1'b0, rep_reg} == (z_reg - ZOOM_W'(1)));
    assign row_end  = (32'(row_reg) == GLYPH_HEIGHT - 1);

    assign glyph_base = ADDR_W'(((32'(char_code) < GLYPH_COUNT) ? 32'(char_code) : 32'd0)
                                * BYTES_PER_GLYPH);
    assign row_addr   = ADDR_W'(32'(base_reg) + 32'(row_reg) * BYTES_PER_LINE);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && is_glyph) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_EMIT;
            ST_EMIT: begin
                if (m_fire && rep_end) begin
                    state_next = row_end ? ST_IDLE : ST_FETCH;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready      = (state_reg == ST_IDLE);
        m_tvalid      = (state_reg == ST_EMIT);
        ram_req.we    = s_fire && action;
        ram_req.addr  = (state_reg == ST_IDLE) ? font_addr : row_addr;
        ram_req.wdata = font_data;
    end

    assign row_x    = x_reg;
    assign row_y    = y_reg;
    assign row_mask = mask_reg;
    assign last_row = rep_end && row_end;

    // cursor
    always_comb begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        if (s_fire && !action) begin
            if (char_code == CODE_CR) begin
                cursor_x_next = COORD_W'(1);
            end else if (char_code == CODE_LF) begin
                cursor_x_next = COORD_W'(1);
                cursor_y_next = sat_add(cursor_y_reg,
                                        COORD_W'(GLYPH_HEIGHT * int'(z_eff)));
            end else if (z_eff != '0) begin
                cursor_x_next = sat_add(cursor_x_reg,
                                        COORD_W'(GLYPH_WIDTH * int'(z_eff)));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cursor_x_reg <= COORD_W'(1);
            cursor_y_reg <= COORD_W'(1);
        end else begin
            state_reg    <= state_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_fire && is_glyph) begin
            x_reg    <= cursor_x_reg;
            y_reg    <= sat_add(cursor_y_reg, COORD_W'(1));
            base_reg <= glyph_base;
            z_reg    <= z_eff;
            row_reg  <= '0;
            rep_reg  <= '0;
        end
        if (state_reg == ST_LOAD) begin
            mask_reg <= expand_row(ram_rdata, z_reg);
        end
        if (state_reg == ST_EMIT && m_fire) begin
            y_reg <= sat_add(y_reg, COORD_W'(1));
            if (rep_end) begin
                rep_reg <= '0;
                row_reg <= row_reg + ROW_W'(1);
            end else begin
                rep_reg <= rep_reg + REP_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/text_cursor_glyph_rasterizer_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// text_cursor_glyph_rasterizer_top
// Bitmap character generator with a text cursor and integer zoom.
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// s_       in   s_tvalid/s_tready    tuser: action; tdata: char_code, font_addr,
//                                    font_data
// m_       out  m_tvalid/m_tready    tdata: row_x, row_y, row_mask, pixel_color;
//                                    tlast: last_row
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data (0 draw_color, 1 zoom)
//
// font writes, carriage return, line feed and zoom zero draw nothing, stay in idle
// a drawn glyph leaves idle: each glyph row is read from the glyph store in fetch
// and load, then sent as zoom output words in emit; no input until the last word
// reset clears cursor and control; the glyph store has no clearing pass
// a stalled output word holds the whole sequencer
// ----------------------------------------------------------------------------
module text_cursor_glyph_rasterizer_top
    import txtc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [31:0]          s_tdata,   // char_code, font_addr, font_data
    input  wire logic [0:0]           s_tuser,   // action
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [127:0]              m_tdata,   // row_x, row_y, row_mask, pixel_color
    output logic                      m_tlast,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COLOR_W-1:0]   cfg_data
);

    logic [COLOR_W-1:0] draw_color_reg;
    logic [ZOOM_W-1:0]  zoom_reg;
    glyph_req_t         ram_req;
    logic [BYTE_W-1:0]  ram_rdata;
    logic [COORD_W-1:0] row_x;
    logic [COORD_W-1:0] row_y;
    logic [MASK_W-1:0]  row_mask;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            draw_color_reg <= DRAW_COLOR_RST;
            zoom_reg       <= ZOOM_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_DRAW_COLOR) begin
                draw_color_reg <= cfg_data;
            end else if (cfg_index == REG_ZOOM) begin
                zoom_reg <= cfg_data[ZOOM_W-1:0];
            end
        end
    end

    txtc_glyph_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    txtc_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .action      (s_tuser[0]),
        .char_code   (s_tdata[7:0]),
        .font_addr   (s_tdata[17:8]),
        .font_data   (s_tdata[25:18]),
        .zoom_factor (zoom_reg),
        .ram_req     (ram_req),
        .ram_rdata   (ram_rdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .row_x       (row_x),
        .row_y       (row_y),
        .row_mask    (row_mask),
        .last_row    (m_tlast)
    );

    assign m_tdata = {draw_color_reg, row_mask, row_y, row_x};

endmodule
`default_nettype wire

@@ bench/txtc_row_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// txtc_row_checker
// Watches the input, result and register channels of the text cursor glyph
// rasterizer. Keeps its own cursor, glyph store and register copies, predicts
// the pixel row words of every accepted input word and compares each output
// word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module txtc_row_checker
    import txtc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [31:0]          s_tdata,
    input  wire logic [0:0]           s_tuser,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [127:0]         m_tdata,
    input  wire logic                 m_tlast,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COLOR_W-1:0]   cfg_data,
    output int                        fail_count,
    output int                        rows_pending
);

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [MASK_W-1:0]  mask;
        logic [COLOR_W-1:0] color;
        logic               last;
    } row_word_t;

    row_word_t          row_queue[$];
    logic [BYTE_W-1:0]  glyph_mem [1024];
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic [COLOR_W-1:0] ink;
    logic [ZOOM_W-1:0]  zoom_reg;
    int                 errors;
    int                 rows_seen;
    row_word_t          got;
    row_word_t          want;

    function automatic logic [COORD_W-1:0] clamp_coord(input int unsigned v);
        return (v > 65535) ? COORD_MAX : COORD_W'(v);
    endfunction

    // glyph store writes, cursor moves and row words caused by one input word
    task automatic rasterize_word(input logic is_font, input logic [CODE_W-1:0] code,
                                  input logic [ADDR_W-1:0] addr,
                                  input logic [BYTE_W-1:0] data);
        int unsigned z;
        int unsigned n_rows;
        int unsigned n_cols;
        int unsigned base;
        logic [BYTE_W-1:0] bits;
        row_word_t w;
        z = (zoom_reg > ZOOM_MAX) ? int'(ZOOM_MAX) : int'(zoom_reg);
        if (is_font) begin
            glyph_mem[addr] = data;
        end else if (code == CODE_CR) begin
            cur_x = 16'd1;
        end else if (code == CODE_LF) begin
            cur_x = 16'd1;
            cur_y = clamp_coord(cur_y + GLYPH_HEIGHT * z);
        end else if (z != 0) begin
            base   = ((code < GLYPH_COUNT) ? code : 0) * BYTES_PER_GLYPH;
            n_rows = GLYPH_HEIGHT * z;
            n_cols = GLYPH_WIDTH * z;
            for (int unsigned i = 1; i <= n_rows; i++) begin
                bits = glyph_mem[(base + ((i - 1) / z) * BYTES_PER_LINE) % 1024];
                w.mask = '0;
                for (int unsigned k = 0; k < n_cols && k < MASK_W; k++) begin
                    w.mask[k] = bits[(k / z) % 8];
                end
                w.x     = cur_x;
                w.y     = clamp_coord(cur_y + i);
                w.color = ink;
                w.last  = (i == n_rows);
                row_queue.push_back(w);
            end
            cur_x = clamp_coord(cur_x + n_cols);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            row_queue.delete();
            cur_x    = 16'd1;
            cur_y    = 16'd1;
            ink      = DRAW_COLOR_RST;
            zoom_reg = ZOOM_RST;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_DRAW_COLOR) begin
                    ink = cfg_data;
                end else if (cfg_index == REG_ZOOM) begin
                    zoom_reg = cfg_data[ZOOM_W-1:0];
                end
            end
            if (s_tvalid && s_tready) begin
                rasterize_word(s_tuser[0], s_tdata[7:0], s_tdata[17:8], s_tdata[25:18]);
            end
            if (m_tvalid && m_tready) begin
                got.x     = m_tdata[15:0];
                got.y     = m_tdata[31:16];
                got.mask  = m_tdata[95:32];
                got.color = m_tdata[127:96];
                got.last  = m_tlast;
                rows_seen++;
                if (row_queue.size() == 0) begin
                    if (errors < 10) begin
                        $display("row word %0d: none expected, got x=%h y=%h mask=%h color=%h last=%b",
                                 rows_seen, got.x, got.y, got.mask, got.color, got.last);
                    end
                    errors++;
                end else begin
                    want = row_queue.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.mask !== want.mask ||
                        got.color !== want.color || got.last !== want.last) begin
                        if (errors < 10) begin
                            $display("row word %0d: exp x=%h y=%h mask=%h color=%h last=%b",
                                     rows_seen, want.x, want.y, want.mask, want.color,
                                     want.last);
                            $display("row word %0d: got x=%h y=%h mask=%h color=%h last=%b",
                                     rows_seen, got.x, got.y, got.mask, got.color, got.last);
                        end
                        errors++;
                    end
                end
            end
        end
        fail_count   <= errors;
        rows_pending <= row_queue.size();
    end

    initial begin
        errors       = 0;
        rows_seen    = 0;
        fail_count   = 0;
        rows_pending = 0;
    end

endmodule

@@ bench/tb_text_cursor_glyph_rasterizer_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_cursor_glyph_rasterizer_top
// Stimulus for the text cursor glyph rasterizer: glyph loads, drawn characters,
// carriage returns and line feeds under several color and zoom settings,
// including zoom zero and zoom above eight. Random gaps on the input side and
// random stalls on the output side. The row checker does the comparison.
// ----------------------------------------------------------------------------
module tb_text_cursor_glyph_rasterizer_top;
    import txtc_pkg::*;

    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_FONT = 1'b1;
    localparam int   IDLE_LIMIT = 2000;
    localparam int   DRAIN_CYCLES = 32;
    localparam logic [63:0] EDGE_GLYPH = 64'hF00F_55AA_8001_00FF;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;   // char_code, font_addr, font_data
    logic [0:0]           s_tuser;   // action
    logic                 m_tvalid;
    logic                 m_tready;
    logic [127:0]         m_tdata;   // row_x, row_y, row_mask, pixel_color
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COLOR_W-1:0]   cfg_data;
    int                   fail_count;
    int                   rows_pending;

    bit                   font_known [1024];
    bit                   calm;
    int                   ready_gap;
    int                   idle_cycles;

    text_cursor_glyph_rasterizer_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    txtc_row_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .rows_pending (rows_pending)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // all glyph rows of the code have been written
    function automatic bit glyph_ready(input int code);
        int g;
        g = (code < GLYPH_COUNT) ? code : 0;
        for (int r = 0; r < GLYPH_HEIGHT; r++) begin
            if (!font_known[(g * BYTES_PER_GLYPH + r * BYTES_PER_LINE) % 1024]) begin
                return 0;
            end
        end
        return 1;
    endfunction

    function automatic int pick_drawable();
        int c;
        c = $urandom_range(0, 255);
        while (c == CODE_CR || c == CODE_LF || !glyph_ready(c)) begin
            c = $urandom_range(0, 255);
        end
        return c;
    endfunction

    task automatic send_word(input logic act, input logic [CODE_W-1:0] code,
                             input logic [ADDR_W-1:0] addr,
                             input logic [BYTE_W-1:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'd0, data, addr, code};
        do @(posedge aclk); while (!s_tready);
        if (act == ACT_FONT) begin
            font_known[addr] = 1'b1;
        end
    endtask

    task automatic font_write(input int addr, input int data);
        send_word(ACT_FONT, CODE_W'($urandom), ADDR_W'(addr), BYTE_W'(data));
    endtask

    task automatic char_word(input int code);
        send_word(ACT_CHAR, CODE_W'(code), ADDR_W'($urandom), BYTE_W'($urandom));
    endtask

    task automatic load_glyph(input int code);
        for (int r = 0; r < GLYPH_HEIGHT; r++) begin
            font_write(code * BYTES_PER_GLYPH + r * BYTES_PER_LINE, $urandom_range(0, 255));
        end
    endtask

    // wait for the last row word, then let trailing words that draw nothing retire
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (rows_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_settings(input logic [COLOR_W-1:0] color,
                                  input logic [ZOOM_W-1:0] zoom);
        cfg_valid <= 1'b1;
        cfg_index <= REG_DRAW_COLOR;
        cfg_data  <= color;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= REG_ZOOM;
        cfg_data  <= {28'($urandom), zoom};
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // output side stalls
    initial begin
        m_tready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            ready_gap = pick_gap();
            if (ready_gap > 0) begin
                m_tready <= 1'b0;
                repeat (ready_gap) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int n;
        int roll;
        int code;
        int zoom;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        calm        = 1'b0;
        idle_cycles = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // edge patterns in glyph 0, top of the store in the last glyph
        for (int r = 0; r < GLYPH_HEIGHT; r++) begin
            font_write(r, EDGE_GLYPH[r*8 +: 8]);
        end
        load_glyph(GLYPH_COUNT - 1);
        char_word(0);
        char_word(GLYPH_COUNT - 1);
        char_word(255);
        char_word(CODE_CR);
        char_word(CODE_LF);

        settle();
        write_settings(32'h0000_0000, 4'd0);
        char_word(0);
        char_word(CODE_LF);

        settle();
        write_settings(32'hFFFF_FFFF, ZOOM_MAX);
        char_word(GLYPH_COUNT - 1);
        char_word(CODE_LF);

        settle();
        write_settings(COLOR_W'($urandom), 4'hF);
        char_word(GLYPH_COUNT);
        char_word(CODE_CR);

        // random phases: glyph loads followed by draws, other draws, returns, line feeds and stray writes
        for (int p = 0; p < 6; p++) begin
            settle();
            calm = ($urandom_range(0, 2) == 0);
            zoom = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 3) : $urandom_range(0, 15);
            write_settings(COLOR_W'($urandom), ZOOM_W'(zoom));
            n = 0;
            while (n < 20) begin
                roll = $urandom_range(0, 99);
                if (roll < 25) begin
                    code = $urandom_range(0, GLYPH_COUNT - 1);
                    load_glyph(code);
                    n += GLYPH_HEIGHT;
                    if (code != CODE_CR && code != CODE_LF) begin
                        repeat ($urandom_range(1, 2)) begin
                            char_word(code);
                            n++;
                        end
                    end
                end else begin
                    if (roll < 55) begin
                        char_word(pick_drawable());
                    end else if (roll < 65) begin
                        char_word(CODE_CR);
                    end else if (roll < 75) begin
                        char_word(CODE_LF);
                    end else begin
                        font_write($urandom_range(0, 1023), $urandom_range(0, 255));
                    end
                    n++;
                end
            end
        end
        calm = 1'b0;

        settle();
        repeat (100) @(posedge aclk);
        if (fail_count == 0 && rows_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/txtc_pkg.sv
hdl/txtc_glyph_ram.sv
hdl/txtc_seq.sv
hdl/text_cursor_glyph_rasterizer_top.sv
bench/txtc_row_checker.sv
bench/tb_text_cursor_glyph_rasterizer_top.sv
